@@ rtl/laser_scan_polar_to_cartesian_macros.svh @@
// Assertion macros shared by the laser scan converter.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef LASER_SCAN_POLAR_TO_CARTESIAN_MACROS_SVH
`define LASER_SCAN_POLAR_TO_CARTESIAN_MACROS_SVH
`ifndef ASSERT_OFF
// The consequence must hold in the same cycle as the condition.
`define LSP2C_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsp2c: same-cycle check failed");
// The consequence must hold in the cycle after the condition.
`define LSP2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsp2c: next-cycle check failed");
`else
`define LSP2C_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LSP2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/lsp2c_pkg.sv @@
`default_nettype none

package lsp2c_pkg;

    // Field widths of the words on the channels.
    localparam int RANGE_W = 16;
    localparam int COORD_W = 17;
    localparam int IDX_W   = 12;
    localparam int ANG_W   = 20;
    localparam int CFG_ANG_W  = 17;
    localparam int CFG_STEP_W = 15;

    // APB port geometry.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Angle constants, radians * 16384.
    localparam int PI_Q14      = 51472;
    localparam int HALF_PI_Q14 = 25736;
    localparam int ACC_MAX     = 524287;

    // Reset values of the registers.
    localparam int START_RST = -51472;
    localparam int STOP_RST  = 51472;
    localparam int STEP_RST  = 57;

    // CORDIC datapath.
    localparam int VEC_W  = 35;
    localparam int GAIN_W = 30;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
    localparam int OUT_LIM = 65535;
    localparam int MAX_STEPS = 24;

    localparam longint ATAN_Q30 [MAX_STEPS] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    typedef enum logic [1:0] {
        REG_ANGLE_START = 2'd0,
        REG_ANGLE_STOP  = 2'd1,
        REG_ANGLE_STEP  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic signed [CFG_ANG_W-1:0] angle_start;
        logic signed [CFG_ANG_W-1:0] angle_stop;
        logic [CFG_STEP_W-1:0]       angle_step;
        logic                        start_wr;
        logic signed [CFG_ANG_W-1:0] start_wdata;
    } t_cfg;

    typedef struct packed {
        logic                        start;
        logic [RANGE_W-1:0]          range;
        logic signed [CFG_ANG_W-1:0] angle;
        logic                        neg;
    } t_cordic_req;

    typedef struct packed {
        logic                      busy;
        logic                      done;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_cordic_rsp;

    // Arctangent of 2^-i rounded to the scale 2^ab per radian.
    function automatic logic [31:0] atan_step(input int i, input int ab);
        longint a;
        a = ATAN_Q30[i];
        return 32'((a + (longint'(1) << (29 - ab))) >>> (30 - ab));
    endfunction

endpackage

`default_nettype wire

@@ rtl/lsp2c_ifs.sv @@
`default_nettype none

interface lsp2c_scan_if;
    logic                              valid;
    logic                              ready;
    logic [lsp2c_pkg::RANGE_W-1:0]     range_mm;
    logic                              range_finite;
    logic                              scan_end;

    modport source (output valid, output range_mm, output range_finite, output scan_end,
                    input ready);
    modport sink   (input valid, input range_mm, input range_finite, input scan_end,
                    output ready);
endinterface

interface lsp2c_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [lsp2c_pkg::COORD_W-1:0] point_x;
    logic signed [lsp2c_pkg::COORD_W-1:0] point_y;
    logic [lsp2c_pkg::IDX_W-1:0]         beam_index;
    logic                                point_valid;
    logic                                last_of_scan;

    modport source (output valid, output point_x, output point_y, output beam_index,
                    output point_valid, output last_of_scan, input ready);
    modport sink   (input valid, input point_x, input point_y, input beam_index,
                    input point_valid, input last_of_scan, output ready);
endinterface

`default_nettype wire

@@ rtl/lsp2c_cfg.sv @@
`default_nettype none

// APB register file for the three angle registers.
module lsp2c_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lsp2c_pkg::APB_AW-1:0]    paddr,
    input  wire logic [lsp2c_pkg::APB_DW-1:0]    pwdata,
    output logic      [lsp2c_pkg::APB_DW-1:0]    prdata,
    output logic                                 pready,
    output lsp2c_pkg::t_cfg                      o_cfg
);

    logic signed [lsp2c_pkg::CFG_ANG_W-1:0] r_start, r_stop;
    logic [lsp2c_pkg::CFG_STEP_W-1:0]       r_step;
    logic                                   w_wr;
    lsp2c_pkg::t_reg_idx                    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = lsp2c_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= lsp2c_pkg::CFG_ANG_W'(lsp2c_pkg::START_RST);
            r_stop  <= lsp2c_pkg::CFG_ANG_W'(lsp2c_pkg::STOP_RST);
            r_step  <= lsp2c_pkg::CFG_STEP_W'(lsp2c_pkg::STEP_RST);
        end else if (w_wr) begin
            case (w_idx)
                lsp2c_pkg::REG_ANGLE_START: r_start <= pwdata[lsp2c_pkg::CFG_ANG_W-1:0];
                lsp2c_pkg::REG_ANGLE_STOP:  r_stop  <= pwdata[lsp2c_pkg::CFG_ANG_W-1:0];
                lsp2c_pkg::REG_ANGLE_STEP:  r_step  <= pwdata[lsp2c_pkg::CFG_STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            lsp2c_pkg::REG_ANGLE_START: prdata = lsp2c_pkg::APB_DW'(r_start);
            lsp2c_pkg::REG_ANGLE_STOP:  prdata = lsp2c_pkg::APB_DW'(r_stop);
            lsp2c_pkg::REG_ANGLE_STEP:  prdata = lsp2c_pkg::APB_DW'(r_step);
            default:                    prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.angle_start = r_start;
        o_cfg.angle_stop  = r_stop;
        o_cfg.angle_step  = r_step;
        o_cfg.start_wr    = w_wr && (w_idx == lsp2c_pkg::REG_ANGLE_START);
        o_cfg.start_wdata = pwdata[lsp2c_pkg::CFG_ANG_W-1:0];
    end

endmodule

`default_nettype wire

@@ rtl/lsp2c_cordic.sv @@
`default_nettype none

// Iterative rotation-mode CORDIC: one gain multiply, then one shift-add
// micro-rotation per cycle, then rounding and saturation.
module lsp2c_cordic #(
    parameter int ANGLE_BITS   = 18,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lsp2c_pkg::t_cordic_req i_req,
    output lsp2c_pkg::t_cordic_rsp   o_rsp
);

    localparam int ZW = ANGLE_BITS + 4;
    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int PW = lsp2c_pkg::RANGE_W + lsp2c_pkg::GAIN_W;
    localparam int VW = lsp2c_pkg::VEC_W;
    localparam int RW = VW - 16;
    localparam int SH = ANGLE_BITS - 14;

    typedef enum logic [3:0] {
        CS_IDLE  = 4'b0001,
        CS_LOAD  = 4'b0010,
        CS_ITER  = 4'b0100,
        CS_ROUND = 4'b1000
    } t_cs_state;

    t_cs_state r_state, n_state;
    logic [CW-1:0]                  r_cnt;
    logic [lsp2c_pkg::RANGE_W-1:0]  r_range;
    logic                           r_neg;
    logic                           r_done;
    logic signed [VW-1:0]           r_x, r_y;
    logic signed [ZW-1:0]           r_z;
    logic signed [lsp2c_pkg::COORD_W-1:0] r_xo, r_yo;

    logic [ZW-1:0]                  w_tab [CORDIC_STEPS];
    logic signed [ZW-1:0]           w_z0, w_t;
    logic [PW-1:0]                  w_prod;
    logic signed [VW-1:0]           w_x0, w_dx, w_dy, w_xr, w_yr;
    logic signed [RW-1:0]           w_rx, w_ry;
    logic signed [lsp2c_pkg::COORD_W-1:0] w_sx, w_sy;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_tab
        assign w_tab[g] = ZW'(lsp2c_pkg::atan_step(g, ANGLE_BITS));
    end

    assign w_z0   = ZW'(i_req.angle) <<< SH;
    assign w_t    = w_tab[r_cnt];
    assign w_prod = PW'(r_range) * PW'(lsp2c_pkg::GAIN_Q30);
    assign w_x0   = VW'((w_prod + PW'(8192)) >> 14);
    assign w_dx   = r_y >>> r_cnt;
    assign w_dy   = r_x >>> r_cnt;
    assign w_xr   = r_x + (VW'(1) <<< 15);
    assign w_yr   = r_y + (VW'(1) <<< 15);

    function automatic logic signed [lsp2c_pkg::COORD_W-1:0] sat_out(
        input logic signed [RW-1:0] v, input logic neg);
        logic signed [RW-1:0] s;
        s = neg ? -v : v;
        if (s > RW'(lsp2c_pkg::OUT_LIM))
            return lsp2c_pkg::COORD_W'(lsp2c_pkg::OUT_LIM);
        if (s < -RW'(lsp2c_pkg::OUT_LIM))
            return -lsp2c_pkg::COORD_W'(lsp2c_pkg::OUT_LIM);
        return s[lsp2c_pkg::COORD_W-1:0];
    endfunction

    assign w_rx = w_xr[VW-1:16];
    assign w_ry = w_yr[VW-1:16];
    assign w_sx = sat_out(w_rx, r_neg);
    assign w_sy = sat_out(w_ry, r_neg);

    always_comb begin
        n_state = r_state;
        case (r_state)
            CS_IDLE:  if (i_req.start) n_state = CS_LOAD;
            CS_LOAD:  n_state = CS_ITER;
            CS_ITER:  if (r_cnt == CW'(CORDIC_STEPS - 1)) n_state = CS_ROUND;
            CS_ROUND: n_state = CS_IDLE;
            default:  n_state = CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == CS_ROUND);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            CS_IDLE: begin
                if (i_req.start) begin
                    r_range <= i_req.range;
                    r_neg   <= i_req.neg;
                    r_z     <= w_z0;
                end
            end
            CS_LOAD: begin
                r_x   <= w_x0;
                r_y   <= '0;
                r_cnt <= '0;
            end
            CS_ITER: begin
                if (r_z >= 0) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_t;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_t;
                end
                r_cnt <= r_cnt + CW'(1);
            end
            CS_ROUND: begin
                r_xo <= w_sx;
                r_yo <= w_sy;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_rsp.busy = (r_state != CS_IDLE);
        o_rsp.done = r_done;
        o_rsp.x    = r_xo;
        o_rsp.y    = r_yo;
    end

endmodule

`default_nettype wire

@@ rtl/laser_scan_polar_to_cartesian.sv @@
// Polar-to-Cartesian converter for a rotating range scan.
// Samples enter on i_scan (valid/ready, one word per sample: range, finite flag,
// end-of-scan flag). Points leave on o_point (valid/ready). The three angle
// registers (start, stop, step, radians * 16384) sit on the APB port at byte
// addresses 0, 4 and 8; pready is always high and writes complete in the access cycle.
// A finite sample at or below the stop angle is rotated by an iterative CORDIC.
// The point appears on o_point in the same cycle as the input is ready again. On the
// way, a converted sample passes the gain load, the micro-rotations in the single
// shift-add rotation unit, one micro-rotation per cycle, the rounding step and the
// handoffs into and out of the rotation unit, and no further sample is accepted
// until its point has been loaded into the output register.
// A dropped sample that ends the scan yields a bare end marker, loaded from the push
// state as soon as the output register is free; any other dropped sample leaves the
// block idle and ready for the next sample and produces no word.
// The output word sits in its own register, so a stalled receiver holds only that
// word: the block still accepts and processes the next sample, and only waits if a
// second result is ready before the first one has been taken.
// After the synchronous reset the registers hold their reset values, the beam angle
// equals the start angle, the beam index is zero and no output word is pending.
`default_nettype none
`include "laser_scan_polar_to_cartesian_macros.svh"

module laser_scan_polar_to_cartesian #(
    parameter int ANGLE_BITS   = 18,
    parameter int RANGE_BITS   = 16,
    parameter int CORDIC_STEPS = 16,
    parameter int MAX_BEAMS    = 4096
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    lsp2c_scan_if.sink                        i_scan,
    lsp2c_point_if.source                     o_point,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lsp2c_pkg::APB_AW-1:0] paddr,
    input  wire logic [lsp2c_pkg::APB_DW-1:0] pwdata,
    output logic      [lsp2c_pkg::APB_DW-1:0] prdata,
    output logic                              pready
);

    localparam int AW = lsp2c_pkg::ANG_W;
    localparam int RMAX = (RANGE_BITS >= lsp2c_pkg::RANGE_W) ?
                          (2 ** lsp2c_pkg::RANGE_W) - 1 : (2 ** RANGE_BITS) - 1;
    localparam int LIMIT_I = (MAX_BEAMS - 1 < 4095) ? MAX_BEAMS - 1 : 4095;
    localparam logic [lsp2c_pkg::IDX_W-1:0] LIMIT = lsp2c_pkg::IDX_W'(LIMIT_I);

    // The control sequencer: idle and ready, waiting on the CORDIC, or holding a
    // finished result until the output register frees up.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_PUSH = 3'b100
    } t_state;

    t_state r_state, n_state;

    lsp2c_pkg::t_cfg        w_cfg;
    lsp2c_pkg::t_cordic_req w_req;
    lsp2c_pkg::t_cordic_rsp w_rsp;

    // Scan state.
    logic signed [AW-1:0]          r_angle;
    logic [lsp2c_pkg::IDX_W-1:0]   r_count;
    logic                          r_beyond;

    // Sideband of the item in flight.
    logic [lsp2c_pkg::IDX_W-1:0]   r_idx;
    logic                          r_conv;
    logic                          r_end;

    // Output register.
    logic                                 r_ovalid;
    logic signed [lsp2c_pkg::COORD_W-1:0] r_ox, r_oy;
    logic [lsp2c_pkg::IDX_W-1:0]          r_oidx;
    logic                                 r_opv, r_olast;

    logic                          w_accept, w_out_free, w_load;
    logic                          w_beyond, w_conv;
    logic signed [AW:0]            w_sum;
    logic signed [AW-1:0]          w_next, w_fold;
    logic                          w_neg;
    logic [lsp2c_pkg::RANGE_W-1:0] w_range;

    lsp2c_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lsp2c_cordic #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign i_scan.ready = (r_state == ST_IDLE);
    assign w_accept     = i_scan.valid && i_scan.ready;
    assign w_out_free   = !r_ovalid || o_point.ready;

    // Once an angle passes the stop angle, the rest of the scan is dropped.
    assign w_beyond = r_beyond || (r_angle > AW'(w_cfg.angle_stop));
    assign w_conv   = i_scan.range_finite && !w_beyond;

    // The running angle saturates at the top; the step is never negative.
    assign w_sum  = (AW + 1)'(r_angle) + (AW + 1)'($signed({1'b0, w_cfg.angle_step}));
    assign w_next = (w_sum > (AW + 1)'(lsp2c_pkg::ACC_MAX)) ?
                    AW'(lsp2c_pkg::ACC_MAX) : w_sum[AW-1:0];

    // Fold the angle into the right half plane; a folded point is negated later.
    always_comb begin
        w_fold = r_angle;
        w_neg  = 1'b0;
        if (r_angle > AW'(lsp2c_pkg::HALF_PI_Q14)) begin
            w_fold = r_angle - AW'(lsp2c_pkg::PI_Q14);
            w_neg  = 1'b1;
        end else if (r_angle < -AW'(lsp2c_pkg::HALF_PI_Q14)) begin
            w_fold = r_angle + AW'(lsp2c_pkg::PI_Q14);
            w_neg  = 1'b1;
        end
    end

    assign w_range = (32'(i_scan.range_mm) > 32'(RMAX)) ?
                     lsp2c_pkg::RANGE_W'(RMAX) : i_scan.range_mm;

    always_comb begin
        w_req.start = w_accept && w_conv;
        w_req.range = w_range;
        w_req.angle = w_fold[lsp2c_pkg::CFG_ANG_W-1:0];
        w_req.neg   = w_neg;
    end

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_conv) begin
                    n_state = ST_BUSY;
                end else if (w_accept && i_scan.scan_end) begin
                    n_state = ST_PUSH;
                end
            end
            ST_BUSY: begin
                if (w_rsp.done) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_PUSH;
                    end
                end
            end
            ST_PUSH: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_angle  <= AW'(lsp2c_pkg::START_RST);
            r_count  <= '0;
            r_beyond <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                if (i_scan.scan_end) begin
                    r_angle  <= AW'(w_cfg.angle_start);
                    r_count  <= '0;
                    r_beyond <= 1'b0;
                end else begin
                    r_angle  <= w_next;
                    r_beyond <= w_beyond;
                    if (r_count < LIMIT) begin
                        r_count <= r_count + lsp2c_pkg::IDX_W'(1);
                    end
                end
            end else if (w_cfg.start_wr && (r_count == '0)) begin
                // A new start angle applies at once while the scan is untouched.
                r_angle <= AW'(w_cfg.start_wdata);
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_point.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx  <= r_count;
            r_conv <= w_conv;
            r_end  <= i_scan.scan_end;
        end
        if (w_load) begin
            r_ox    <= r_conv ? w_rsp.x : '0;
            r_oy    <= r_conv ? w_rsp.y : '0;
            r_oidx  <= r_idx;
            r_opv   <= r_conv;
            r_olast <= r_end;
        end
    end

    assign o_point.valid        = r_ovalid;
    assign o_point.point_x      = r_ox;
    assign o_point.point_y      = r_oy;
    assign o_point.beam_index   = r_oidx;
    assign o_point.point_valid  = r_opv;
    assign o_point.last_of_scan = r_olast;

    // A converted sample always sets the rotation unit running.
    `LSP2C_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, w_accept && w_conv, w_rsp.busy)
    // The rotation unit only finishes while the sequencer waits on it.
    `LSP2C_ASSERT_NOW(a_done_in_busy, i_clk, i_rst_n, w_rsp.done, r_state == ST_BUSY)
    // The input is never offered while the rotation unit still works.
    `LSP2C_ASSERT_NOW(a_ready_idle, i_clk, i_rst_n, i_scan.ready, !w_rsp.busy)
    // A bare end marker has zero coordinates and closes a scan.
    `LSP2C_ASSERT_NOW(a_bare_marker, i_clk, i_rst_n, r_ovalid && !r_opv,
                      r_olast && (r_ox == '0) && (r_oy == '0))

endmodule

`default_nettype wire

@@ tb/sv/tb_laser_scan_polar_to_cartesian.sv @@
`default_nettype none

// Self-checking testbench for the laser scan polar-to-Cartesian converter.
// Range samples go in on the scan channel and points come out on the point channel.
// Every word accepted on the scan channel is run through a predictor that mirrors the
// converter: running beam angle, stop detection, sample index and a bit-true CORDIC.
// The predictor queues the point word that the sample should cause, if any.
// Every word taken from the point channel is compared field by field with the oldest
// queued word. The angle registers are written over the APB port only while the block
// is idle, and each write to a mapped register is read back.
module tb_laser_scan_polar_to_cartesian;
    timeunit 1ns;
    timeprecision 1ps;

    // Parameters of the block under test; the predictor uses the same values.
    localparam int ANGLE_BITS   = 18;
    localparam int RANGE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int MAX_BEAMS    = 4096;

    // Fixed-point constants of the conversion, radians * 16384 for angles.
    localparam longint PI_ANGLE      = 51472;
    localparam longint HALF_PI_ANGLE = 25736;
    localparam longint GAIN_Q30      = 652032874;
    localparam longint ANGLE_SAT_HI  = 524287;
    localparam longint ANGLE_SAT_LO  = -524288;
    localparam longint COORD_LIMIT   = 65535;
    localparam longint RANGE_MAX     = (longint'(1) << RANGE_BITS) - 1;
    localparam int     INDEX_LIMIT   = (MAX_BEAMS - 1 < 4095) ? MAX_BEAMS - 1 : 4095;

    // Arctangent of 2^-i in radians * 2^30.
    localparam longint ARCTAN_Q30 [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    // A register index past the end of the map; writes to it must be ignored.
    localparam int unsigned REG_UNMAPPED = 3;

    // Handshake behavior and run bounds.
    localparam int IDLE_PCT      = 17;
    localparam int SETTLE_CYCLES = CORDIC_STEPS + 12;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic signed [lsp2c_pkg::COORD_W-1:0] point_x;
        logic signed [lsp2c_pkg::COORD_W-1:0] point_y;
        logic [lsp2c_pkg::IDX_W-1:0]          beam_index;
        logic                                 point_valid;
        logic                                 last_of_scan;
    } t_point_word;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [lsp2c_pkg::APB_AW-1:0] paddr;
    logic [lsp2c_pkg::APB_DW-1:0] pwdata;
    logic [lsp2c_pkg::APB_DW-1:0] prdata;
    logic                         pready;

    lsp2c_scan_if  scan_bus();
    lsp2c_point_if point_bus();

    laser_scan_polar_to_cartesian #(
        .ANGLE_BITS  (ANGLE_BITS),
        .RANGE_BITS  (RANGE_BITS),
        .CORDIC_STEPS(CORDIC_STEPS),
        .MAX_BEAMS   (MAX_BEAMS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_scan (scan_bus),
        .o_point(point_bus),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Predictor copy of the registers and of the scan state.
    longint      cfg_start;
    longint      cfg_stop;
    longint      cfg_step;
    longint      beam_angle;
    int          sample_count;
    bit          beyond_stop;
    t_point_word expected_points[$];

    // While set, neither side of the streaming ports inserts idle cycles.
    bit steady_flow = 1'b0;

    int mismatches      = 0;
    int samples_sent    = 0;
    int scans_sent      = 0;
    int points_checked  = 0;
    int markers_checked = 0;
    int register_writes = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Run stopped by the watchdog before the stimulus completed.");
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Rotation-mode CORDIC on the beam angle. Angles beyond a quarter turn are folded
    // by half a turn first, and the folded result has both coordinates negated.
    function automatic void rotate_beam(input longint range_val, input longint angle,
                                        output longint px, output longint py);
        bit     folded;
        longint vx, vy, resid, dx, dy, micro;
        folded = 1'b0;
        if (angle > HALF_PI_ANGLE) begin
            angle -= PI_ANGLE;
            folded = 1'b1;
        end else if (angle < -HALF_PI_ANGLE) begin
            angle += PI_ANGLE;
            folded = 1'b1;
        end
        resid = angle * (longint'(1) << (ANGLE_BITS - 14));
        // The start vector carries the CORDIC gain and 16 fraction bits.
        vx = (range_val * GAIN_Q30 + (longint'(1) << 13)) >>> 14;
        vy = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            micro = (ARCTAN_Q30[i] + (longint'(1) << (29 - ANGLE_BITS))) >>> (30 - ANGLE_BITS);
            if (resid >= 0) begin
                vx -= dx;
                vy += dy;
                resid -= micro;
            end else begin
                vx += dx;
                vy -= dy;
                resid += micro;
            end
        end
        vx = (vx + 32768) >>> 16;
        vy = (vy + 32768) >>> 16;
        if (folded) begin
            vx = -vx;
            vy = -vy;
        end
        px = (vx > COORD_LIMIT) ? COORD_LIMIT : ((vx < -COORD_LIMIT) ? -COORD_LIMIT : vx);
        py = (vy > COORD_LIMIT) ? COORD_LIMIT : ((vy < -COORD_LIMIT) ? -COORD_LIMIT : vy);
    endfunction

    function automatic void reset_predictor();
        cfg_start    = lsp2c_pkg::START_RST;
        cfg_stop     = lsp2c_pkg::STOP_RST;
        cfg_step     = lsp2c_pkg::STEP_RST;
        beam_angle   = cfg_start;
        sample_count = 0;
        beyond_stop  = 1'b0;
        expected_points.delete();
    endfunction

    // A new start angle is used at the next scan start, or at once if the current
    // scan has not taken a sample yet. Unknown indexes leave everything as it was.
    function automatic void apply_register(input int unsigned index,
                                           input logic [lsp2c_pkg::APB_DW-1:0] value);
        case (index)
            lsp2c_pkg::REG_ANGLE_START: begin
                cfg_start = longint'($signed(value[lsp2c_pkg::CFG_ANG_W-1:0]));
                if (sample_count == 0)
                    beam_angle = cfg_start;
            end
            lsp2c_pkg::REG_ANGLE_STOP:
                cfg_stop = longint'($signed(value[lsp2c_pkg::CFG_ANG_W-1:0]));
            lsp2c_pkg::REG_ANGLE_STEP:
                cfg_step = longint'(value[lsp2c_pkg::CFG_STEP_W-1:0]);
            default: ;
        endcase
    endfunction

    // Advances the scan state by one accepted sample and queues the word it causes.
    function automatic void predict_sample(input logic [lsp2c_pkg::RANGE_W-1:0] range_in,
                                           input logic finite, input logic last);
        longint      range_val, px, py, next_angle;
        bit          converted;
        t_point_word want;
        range_val = range_in;
        if (range_val > RANGE_MAX)
            range_val = RANGE_MAX;
        px = 0;
        py = 0;
        want.beam_index = lsp2c_pkg::IDX_W'(sample_count);
        // Once the angle passes the stop angle, the rest of the scan is dropped.
        if (!beyond_stop && beam_angle > cfg_stop)
            beyond_stop = 1'b1;
        converted = finite && !beyond_stop;
        if (converted)
            rotate_beam(range_val, beam_angle, px, py);
        next_angle = beam_angle + cfg_step;
        beam_angle = (next_angle > ANGLE_SAT_HI) ? ANGLE_SAT_HI :
                     ((next_angle < ANGLE_SAT_LO) ? ANGLE_SAT_LO : next_angle);
        if (sample_count < INDEX_LIMIT)
            sample_count++;
        if (last) begin
            beam_angle   = cfg_start;
            sample_count = 0;
            beyond_stop  = 1'b0;
        end
        // The last sample of a scan always yields a word, a bare marker if dropped.
        if (converted || last) begin
            want.point_x      = lsp2c_pkg::COORD_W'(px);
            want.point_y      = lsp2c_pkg::COORD_W'(py);
            want.point_valid  = converted;
            want.last_of_scan = last;
            expected_points   = {expected_points, want};
        end
    endfunction

    // ------------------------------------------------------------------
    // Channel monitors and the receiving side
    // ------------------------------------------------------------------

    // Every sample word accepted by the block updates the predictor at that edge.
    always @(posedge i_clk) begin
        if (i_rst_n && scan_bus.valid && scan_bus.ready) begin
            predict_sample(scan_bus.range_mm, scan_bus.range_finite, scan_bus.scan_end);
            samples_sent++;
            if (scan_bus.scan_end)
                scans_sent++;
        end
    end

    task automatic check_point_word();
        t_point_word want;
        if (expected_points.size() == 0) begin
            report_mismatch("point word with no sample pending, beam_index",
                            point_bus.beam_index, -1);
            return;
        end
        want = expected_points.pop_front();
        if (point_bus.point_x !== want.point_x)
            report_mismatch("point_x", point_bus.point_x, want.point_x);
        if (point_bus.point_y !== want.point_y)
            report_mismatch("point_y", point_bus.point_y, want.point_y);
        if (point_bus.beam_index !== want.beam_index)
            report_mismatch("beam_index", point_bus.beam_index, want.beam_index);
        if (point_bus.point_valid !== want.point_valid)
            report_mismatch("point_valid", point_bus.point_valid, want.point_valid);
        if (point_bus.last_of_scan !== want.last_of_scan)
            report_mismatch("last_of_scan", point_bus.last_of_scan, want.last_of_scan);
        if (want.point_valid)
            points_checked++;
        else
            markers_checked++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && point_bus.valid && point_bus.ready)
            check_point_word();
    end

    // The receiver stalls at random, except during the steady stretch.
    initial point_bus.ready = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n)
            point_bus.ready <= 1'b0;
        else
            point_bus.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Sender and register access
    // ------------------------------------------------------------------

    // Offers one sample word and returns at the edge that accepts it. Valid stays
    // high afterwards so that a following word can go out back to back.
    task automatic send_sample(input logic [lsp2c_pkg::RANGE_W-1:0] range_in,
                               input logic finite, input logic last);
        if (!steady_flow) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                scan_bus.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        scan_bus.valid        <= 1'b1;
        scan_bus.range_mm     <= range_in;
        scan_bus.range_finite <= finite;
        scan_bus.scan_end     <= last;
        do
            @(posedge i_clk);
        while (!scan_bus.ready);
    endtask

    // Lowers valid, waits for every queued word and then lets the block settle, since
    // a dropped sample may still be in flight when the last word has been seen.
    task automatic wait_drained();
        int cycles;
        scan_bus.valid <= 1'b0;
        cycles = 0;
        do begin
            @(posedge i_clk);
            cycles++;
        end while (expected_points.size() != 0 && cycles < DRAIN_LIMIT);
        if (expected_points.size() != 0) begin
            report_mismatch("point words never delivered", 0, expected_points.size());
            expected_points.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: a setup cycle, then an access cycle that ends when pready is
    // high. A write takes effect at that edge, which is where the predictor follows.
    task automatic apb_transfer(input bit write, input int unsigned index,
                                input logic [lsp2c_pkg::APB_DW-1:0] wdata,
                                output logic [lsp2c_pkg::APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= lsp2c_pkg::APB_AW'(index * 4);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        rdata = prdata;
        if (write)
            apply_register(index, wdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(input int unsigned index, input longint want);
        logic [lsp2c_pkg::APB_DW-1:0] rdata, mask;
        mask = (index == lsp2c_pkg::REG_ANGLE_STEP) ?
               lsp2c_pkg::APB_DW'((1 << lsp2c_pkg::CFG_STEP_W) - 1) :
               lsp2c_pkg::APB_DW'((1 << lsp2c_pkg::CFG_ANG_W) - 1);
        apb_transfer(1'b0, index, '0, rdata);
        if ((rdata & mask) !== (lsp2c_pkg::APB_DW'(want) & mask))
            report_mismatch($sformatf("read-back of register %0d", index),
                            longint'(rdata & mask),
                            longint'(lsp2c_pkg::APB_DW'(want) & mask));
    endtask

    task automatic write_register(input int unsigned index, input longint value);
        logic [lsp2c_pkg::APB_DW-1:0] rdata;
        apb_transfer(1'b1, index, lsp2c_pkg::APB_DW'(value), rdata);
        register_writes++;
        if (index != REG_UNMAPPED)
            check_register(index, value);
    endtask

    task automatic set_angles(input longint start_angle, input longint stop_angle,
                              input longint step_angle);
        write_register(lsp2c_pkg::REG_ANGLE_START, start_angle);
        write_register(lsp2c_pkg::REG_ANGLE_STOP, stop_angle);
        write_register(lsp2c_pkg::REG_ANGLE_STEP, step_angle);
    endtask

    // ------------------------------------------------------------------
    // Random value helpers
    // ------------------------------------------------------------------

    function automatic logic [lsp2c_pkg::RANGE_W-1:0] random_range();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return lsp2c_pkg::RANGE_W'($urandom_range(0, 255));
            default: return lsp2c_pkg::RANGE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly the working span of the angle registers, with its ends weighted up
    // and now and then any value the 17-bit field can hold.
    function automatic longint random_angle();
        case ($urandom_range(0, 9))
            0:       return -PI_ANGLE;
            1:       return PI_ANGLE;
            2:       return longint'($signed(lsp2c_pkg::CFG_ANG_W'($urandom_range(0, 131071))));
            default: return longint'($urandom_range(0, 102944)) - PI_ANGLE;
        endcase
    endfunction

    function automatic longint random_step();
        case ($urandom_range(0, 19))
            0, 1:    return 1;
            2, 3:    return 16384;
            4:       return 0;
            5:       return longint'($urandom_range(0, 32767));
            default: return longint'($urandom_range(1, 600));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_register_reset();
        check_register(lsp2c_pkg::REG_ANGLE_START, lsp2c_pkg::START_RST);
        check_register(lsp2c_pkg::REG_ANGLE_STOP, lsp2c_pkg::STOP_RST);
        check_register(lsp2c_pkg::REG_ANGLE_STEP, lsp2c_pkg::STEP_RST);
    endtask

    // Range extremes, non-finite samples, folding on both sides, the stop angle,
    // bare end markers, an empty angle window, a zero step and an unmapped write.
    task automatic test_directed_corners();
        send_sample(16'd0, 1'b1, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b0);
        send_sample(16'hFFFF, 1'b0, 1'b0);
        send_sample(16'd1, 1'b1, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b1);
        // A scan made of one non-finite sample only gives the bare end marker.
        send_sample(16'd1234, 1'b0, 1'b1);
        wait_drained();

        // One-radian steps over the full span: folded angles on both ends, then the
        // stop angle is passed and the scan ends with a bare marker.
        set_angles(-PI_ANGLE, PI_ANGLE, 16384);
        for (int i = 0; i < 9; i++)
            send_sample(16'hFFFF, 1'b1, i == 8);
        wait_drained();

        // The start lies beyond the stop, so nothing but the end marker comes out.
        set_angles(PI_ANGLE, -PI_ANGLE, 16384);
        send_sample(16'hFFFF, 1'b1, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b1);
        wait_drained();

        // With a zero step every sample sits on the start angle; the two starts are
        // just inside and just outside a quarter turn.
        set_angles(HALF_PI_ANGLE, PI_ANGLE, 0);
        send_sample(16'd40000, 1'b1, 1'b0);
        send_sample(16'd40000, 1'b1, 1'b1);
        wait_drained();
        set_angles(HALF_PI_ANGLE + 1, PI_ANGLE, 0);
        send_sample(16'd40000, 1'b1, 1'b0);
        send_sample(16'd40000, 1'b1, 1'b1);
        wait_drained();

        // A write past the register map must change nothing.
        write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_sample(16'd777, 1'b1, 1'b0);
        send_sample(16'd777, 1'b1, 1'b1);
        wait_drained();
    endtask

    // A start angle written in the middle of a scan waits for the next scan; one
    // written before the first sample of a scan applies to that sample.
    task automatic test_start_angle_update();
        set_angles(-PI_ANGLE, PI_ANGLE, 300);
        for (int i = 0; i < 3; i++)
            send_sample(random_range(), 1'b1, 1'b0);
        wait_drained();
        write_register(lsp2c_pkg::REG_ANGLE_START, 0);
        send_sample(16'd5000, 1'b1, 1'b0);
        send_sample(16'd5000, 1'b1, 1'b1);
        send_sample(16'd5000, 1'b1, 1'b0);
        send_sample(16'd5000, 1'b1, 1'b1);
        wait_drained();
        write_register(lsp2c_pkg::REG_ANGLE_START, -10000);
        send_sample(16'd5000, 1'b1, 1'b0);
        send_sample(16'd5000, 1'b1, 1'b1);
        wait_drained();
    endtask

    // Full-field register values and the largest step drive the angle accumulator
    // into its upper limit within one scan.
    task automatic test_angle_saturation();
        set_angles(-65536, 65535, 32767);
        for (int i = 0; i < 40; i++)
            send_sample(random_range(), i < 6 || $urandom_range(0, 3) == 0, i == 39);
        wait_drained();
    endtask

    // Random register settings, each followed by scans of random length with random
    // ranges and an occasional non-finite sample.
    task automatic test_random_scans();
        int sent, scan_len;
        for (int phase = 0; phase < 8; phase++) begin
            steady_flow = (phase == 4 || phase == 5);
            set_angles(random_angle(), random_angle(), random_step());
            sent = 0;
            while (sent < 150) begin
                scan_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 40)
                                                      : $urandom_range(41, 160);
                for (int i = 0; i < scan_len; i++)
                    send_sample(random_range(), $urandom_range(99) < 85, i == scan_len - 1);
                sent += scan_len;
            end
            wait_drained();
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        scan_bus.valid        = 1'b0;
        scan_bus.range_mm     = '0;
        scan_bus.range_finite = 1'b0;
        scan_bus.scan_end     = 1'b0;
        reset_predictor();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_reset();
        test_directed_corners();
        test_start_angle_update();
        test_angle_saturation();
        test_random_scans();
        wait_drained();

        $display("Sent %0d samples in %0d scans over %0d register writes.",
                 samples_sent, scans_sent, register_writes);
        $display("Checked %0d converted points and %0d bare end markers, %0d mismatches.",
                 points_checked, markers_checked, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/lsp2c_pkg.sv
rtl/lsp2c_ifs.sv
rtl/lsp2c_cfg.sv
rtl/lsp2c_cordic.sv
rtl/laser_scan_polar_to_cartesian.sv
tb/sv/tb_laser_scan_polar_to_cartesian.sv
